>>> design/bsst_pkg.sv
package bsst_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  // Default storage depth
  localparam int unsigned MAX_ENTRIES_DEF = 1024;

  // Reset value of the capacity register
  localparam logic [COUNT_W-1:0] CAPACITY_RESET = COUNT_W'(1024);

  // Register indexes (byte address is 4 * index)
  localparam logic REG_CAPACITY = 1'b0;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_SPAN,
    ST_RESULT
  } state_e;

  // Sequencer controls toward the datapath
  typedef struct packed {
    logic               in_ready;
    logic               rd_en;
    logic [COUNT_W-1:0] rd_idx;
    logic               span_en;
    logic               out_load;
  } seq_ctl_t;

endpackage

>>> design/bounded_set_span_tracker.sv
// Each accepted item is scanned against the N entries held before it, then the span
// is taken and the result loaded; a rejected item or an empty set skips the scan.
// No new item is taken until its result is loaded; the scan is set by the
// single memory read port and the shared gap unit visiting one entry a cycle,
// and the result load waits while the result channel is stalled.
// Reset: asynchronous active low; set empty, min/max zero, gap all ones, capacity 1024.
module bounded_set_span_tracker #(
  parameter int unsigned MAX_ENTRIES = bsst_pkg::MAX_ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [bsst_pkg::VALUE_W-1:0] new_value_i,
  // Result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         rejected_full_o,
  output logic [bsst_pkg::COUNT_W-1:0] element_count_o,
  output logic                         spans_valid_o,
  output logic [bsst_pkg::VALUE_W-1:0] longest_span_o,
  output logic [bsst_pkg::VALUE_W-1:0] shortest_span_o,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsst_pkg::PADDR_W-1:0] paddr,
  input  logic [bsst_pkg::PDATA_W-1:0] pwdata,
  output logic [bsst_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import bsst_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_ENTRIES);

  seq_ctl_t           ctl;
  logic               in_accept;
  logic               out_free;
  logic               full;
  logic               scan_req;
  logic               cfg_write;
  logic [COUNT_W-1:0] cap_q;
  logic [COUNT_W-1:0] count_q;
  logic [VALUE_W-1:0] value_q;
  logic               full_q;
  logic signed [VALUE_W-1:0] min_q;
  logic signed [VALUE_W-1:0] max_q;
  logic [VALUE_W-1:0] gap_min_q;
  logic [VALUE_W-1:0] mem [MAX_ENTRIES];
  logic [VALUE_W-1:0] rdata_q;
  logic               rd_vld_q;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [VALUE_W-1:0] unit_a;
  logic [VALUE_W-1:0] unit_b;
  logic               gap_vld;
  logic               gap_scan;
  logic [VALUE_W-1:0] gap;
  logic               spans_ok;
  logic               out_valid_q;
  logic               rejected_q;
  logic [COUNT_W-1:0] count_out_q;
  logic               spans_valid_q;
  logic [VALUE_W-1:0] longest_q;
  logic [VALUE_W-1:0] shortest_q;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAPACITY_RESET;
    end else if (cfg_write) begin
      cap_q <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = {{(PDATA_W-COUNT_W){1'b0}}, cap_q};
    end
  end

  // Admission decision
  assign in_ready_o = ctl.in_ready;
  assign in_accept  = in_valid_i && ctl.in_ready;
  assign full       = (count_q >= cap_q) || (32'(count_q) >= 32'(MAX_ENTRIES));
  assign scan_req   = !full && (count_q != '0);
  assign out_free   = !out_valid_q || out_ready_i;

  bsst_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .scan_req_i  (scan_req),
    .scan_last_i (count_q - COUNT_W'(1)),
    .pipe_busy_i (rd_vld_q || gap_vld),
    .out_free_i  (out_free),
    .ctl_o       (ctl)
  );

  // Latch the item, store it and update count, min and max
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      min_q   <= '0;
      max_q   <= '0;
      full_q  <= 1'b0;
      value_q <= '0;
    end else if (in_accept) begin
      full_q  <= full;
      value_q <= new_value_i;
      if (!full) begin
        count_q <= count_q + COUNT_W'(1);
        if (count_q == '0) begin
          min_q <= new_value_i;
          max_q <= new_value_i;
        end else begin
          if (new_value_i < min_q) begin
            min_q <= new_value_i;
          end
          if (new_value_i > max_q) begin
            max_q <= new_value_i;
          end
        end
      end
    end
  end

  // Value memory: one write port, one registered read port
  assign wr_addr = ADDR_W'(count_q);
  assign rd_addr = ADDR_W'(ctl.rd_idx);

  always_ff @(posedge clk_i) begin
    if (in_accept && !full) begin
      mem[wr_addr] <= new_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= ctl.rd_en;
    end
  end

  // Shared gap unit: scanned entries, then max against min
  assign unit_a = ctl.span_en ? max_q : value_q;
  assign unit_b = ctl.span_en ? min_q : rdata_q;

  bsst_gap_unit u_gap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_vld_q || ctl.span_en),
    .scan_i  (rd_vld_q),
    .a_i     (unit_a),
    .b_i     (unit_b),
    .valid_o (gap_vld),
    .scan_o  (gap_scan),
    .gap_o   (gap)
  );

  // Lower the smallest gap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_min_q <= '1;
    end else if (gap_vld && gap_scan && (gap < gap_min_q)) begin
      gap_min_q <= gap;
    end
  end

  // Result register
  assign spans_ok = (count_q >= COUNT_W'(2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      rejected_q    <= full_q;
      count_out_q   <= count_q;
      spans_valid_q <= spans_ok;
      longest_q     <= spans_ok ? gap : '0;
      shortest_q    <= spans_ok ? gap_min_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign rejected_full_o = rejected_q;
  assign element_count_o = count_out_q;
  assign spans_valid_o   = spans_valid_q;
  assign longest_span_o  = longest_q;
  assign shortest_span_o = shortest_q;

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(MAX_ENTRIES))
    else $error("held count exceeds storage depth");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> (min_q <= max_q))
    else $error("running min above running max");

  a_gap_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (gap_min_q <= $past(gap_min_q)))
    else $error("smallest gap increased");

  a_load_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!rd_vld_q && !gap_scan))
    else $error("result loaded while scan still in flight");

  a_accept_idle_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!rd_vld_q && !gap_vld && !ctl.rd_en))
    else $error("item accepted during a scan");
`endif

endmodule

>>> design/bsst_gap_unit.sv
module bsst_gap_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic                        scan_i,
  input  logic [bsst_pkg::VALUE_W-1:0] a_i,
  input  logic [bsst_pkg::VALUE_W-1:0] b_i,
  output logic                        valid_o,
  output logic                        scan_o,
  output logic [bsst_pkg::VALUE_W-1:0] gap_o
);
  import bsst_pkg::*;

  logic [VALUE_W-1:0] key_a;
  logic [VALUE_W-1:0] key_b;
  logic [VALUE_W:0]   diff_ab;
  logic [VALUE_W:0]   diff_ba;
  logic [VALUE_W-1:0] gap_d;
  logic [VALUE_W-1:0] gap_q;
  logic               valid_q;
  logic               scan_q;

  // Flip the sign bit so unsigned order matches signed order
  assign key_a = {~a_i[VALUE_W-1], a_i[VALUE_W-2:0]};
  assign key_b = {~b_i[VALUE_W-1], b_i[VALUE_W-2:0]};

  // Take both differences and keep the one that did not borrow
  assign diff_ab = {1'b0, key_a} - {1'b0, key_b};
  assign diff_ba = {1'b0, key_b} - {1'b0, key_a};
  assign gap_d   = diff_ab[VALUE_W] ? diff_ba[VALUE_W-1:0] : diff_ab[VALUE_W-1:0];

  // Track which operation is in flight
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      scan_q  <= 1'b0;
    end else begin
      valid_q <= valid_i;
      scan_q  <= valid_i & scan_i;
    end
  end

  // Hold the last result until a new operation arrives
  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      gap_q <= gap_d;
    end
  end

  assign valid_o = valid_q;
  assign scan_o  = scan_q;
  assign gap_o   = gap_q;

endmodule

>>> design/bsst_seq.sv
module bsst_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         scan_req_i,
  input  logic [bsst_pkg::COUNT_W-1:0] scan_last_i,
  input  logic                         pipe_busy_i,
  input  logic                         out_free_i,
  output bsst_pkg::seq_ctl_t           ctl_o
);
  import bsst_pkg::*;

  state_e             state_q;
  state_e             state_d;
  logic [COUNT_W-1:0] idx_q;
  logic [COUNT_W-1:0] idx_d;
  logic [COUNT_W-1:0] last_q;
  logic [COUNT_W-1:0] last_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = scan_req_i ? ST_SCAN : ST_SPAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == last_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy_i) begin
          state_d = ST_SPAN;
        end
      end
      ST_SPAN: begin
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Scan index and last index
  always_comb begin
    idx_d  = idx_q;
    last_d = last_q;
    if (state_q == ST_IDLE && start_i) begin
      idx_d  = '0;
      last_d = scan_last_i;
    end else if (state_q == ST_SCAN) begin
      idx_d = idx_q + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
    end
  end

  // Outputs
  always_comb begin
    ctl_o.in_ready = (state_q == ST_IDLE);
    ctl_o.rd_en    = (state_q == ST_SCAN);
    ctl_o.rd_idx   = idx_q;
    ctl_o.span_en  = (state_q == ST_SPAN);
    ctl_o.out_load = (state_q == ST_RESULT) && out_free_i;
  end

endmodule
